### rtl/core/window_roulette_sampler_macros.svh
// ----------------------------------------------------------------------------
// window_roulette_sampler assertion macros
// Clocked, reset-gated property wrappers used by the sampler top level.
// ----------------------------------------------------------------------------
`ifndef WINDOW_ROULETTE_SAMPLER_MACROS_SVH
`define WINDOW_ROULETTE_SAMPLER_MACROS_SVH

// same-cycle implication
`define WRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler assertion failed");

// next-cycle implication
`define WRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler assertion failed");

`endif

### rtl/core/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the window roulette sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int FRAC_CNT_BITS = 4;
  localparam int COORD_BITS    = 4;
  localparam int PADDR_BITS    = 4;
  localparam int PDATA_BITS    = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_ROWS,
    ST_COLS,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [15:0]           weight;
    logic [FRAC_BITS-1:0]  random_fraction;
  } req_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pick_x;
    logic [COORD_BITS-1:0] pick_y;
  } rsp_item_t;

  typedef struct packed {
    logic ready;
    logic done;
  } eng_status_t;

endpackage

`default_nettype wire

### rtl/core/wrs_grid.sv
// ----------------------------------------------------------------------------
// wrs_grid
// Weight store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_grid #(
  parameter int AW = 8,
  parameter int WB = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [WB-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [WB-1:0] rdata
);

  logic [WB-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/wrs_engine.sv
// ----------------------------------------------------------------------------
// wrs_engine
// Sequencer around one shared adder: window total, target multiply,
// row search and column search, plus the clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_engine #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int XW          = 4,
  parameter int YW          = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wrs_pkg::req_item_t   req,
  input  wire logic                 req_accept,
  input  wire logic [XW-1:0]        x0,
  input  wire logic [XW-1:0]        x1,
  input  wire logic [YW-1:0]        y0,
  input  wire logic [YW-1:0]        y1,
  input  wire logic                 res_take,
  output wrs_pkg::eng_status_t      status,
  output wrs_pkg::rsp_item_t        res
);

  import wrs_pkg::*;

  localparam int AW = XW + YW;
  localparam int TW = WEIGHT_BITS + XW + YW;
  localparam int PW = TW + FRAC_BITS;

  state_t state, state_next;

  logic [AW-1:0]            clr_addr;
  logic [PW-1:0]            acc;
  logic [TW-1:0]            total;
  logic [TW-1:0]            target;
  logic [TW-1:0]            row_base;
  logic [FRAC_BITS-1:0]     frac;
  logic [FRAC_CNT_BITS-1:0] cnt;
  logic [XW-1:0]            sx;
  logic [YW-1:0]            sy;
  logic                     iss;
  logic                     rd_vld;
  logic                     rd_eol;
  logic                     rd_last;
  logic [XW-1:0]            rd_x;
  logic [YW-1:0]            rd_y;
  logic [XW-1:0]            pick_x;
  logic [YW-1:0]            pick_y;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [WEIGHT_BITS-1:0]   wdata;
  logic [WEIGHT_BITS-1:0]   rdata;
  logic                     wr_hit;

  logic [PW-1:0]            add_a;
  logic [PW-1:0]            add_b;
  logic [PW-1:0]            sum;
  logic                     hit;
  logic                     iss_last;
  logic                     mul_last;

  wrs_grid #(
    .AW (AW),
    .WB (WEIGHT_BITS)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr ({sy, sx}),
    .rdata (rdata)
  );

  // shared adder: accumulate weights, or shift-and-add the target product
  always_comb begin
    if (state == ST_MUL) begin
      add_a = {acc[PW-2:0], 1'b0};
      add_b = frac[FRAC_BITS-1] ? PW'(total) : '0;
    end else begin
      add_a = acc;
      add_b = PW'(rdata);
    end
    sum      = add_a + add_b;
    hit      = (sum >= PW'(target));
    iss_last = (sx == x1) && ((state == ST_COLS) || (sy == y1));
    mul_last = (cnt == FRAC_CNT_BITS'(FRAC_BITS - 1));
  end

  // write port: clearing sweep, else accepted write items inside the grid
  always_comb begin
    wr_hit = req_accept && (req.op == OP_WRITE) &&
             (32'(req.cell_x) < GRID_WIDTH) && (32'(req.cell_y) < GRID_HEIGHT);
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = wr_hit;
      waddr = {YW'(req.cell_y), XW'(req.cell_x)};
      wdata = WEIGHT_BITS'(req.weight);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_accept && (req.op == OP_SAMPLE)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_vld && rd_last) begin
          state_next = (sum == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_next = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (rd_vld && rd_eol && (hit || rd_last)) begin
          state_next = ST_COLS;
        end
      end
      ST_COLS: begin
        if (rd_vld && (hit || rd_last)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    status.ready = (state == ST_IDLE);
    status.done  = (state == ST_DONE);
    res.pick_x   = COORD_BITS'(pick_x);
    res.pick_y   = COORD_BITS'(pick_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      iss      <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end

      // read pipeline: data for the address issued now arrives next cycle
      rd_vld  <= iss;
      rd_eol  <= (sx == x1);
      rd_last <= iss_last;
      rd_x    <= sx;
      rd_y    <= sy;

      // advance the scan address
      if (iss) begin
        if (sx == x1) begin
          sx <= x0;
          if (iss_last) begin
            iss <= 1'b0;
          end else begin
            sy <= sy + YW'(1);
          end
        end else begin
          sx <= sx + XW'(1);
        end
      end

      case (state)
        ST_IDLE: begin
          if (req_accept && (req.op == OP_SAMPLE)) begin
            frac   <= req.random_fraction;
            acc    <= '0;
            sx     <= x0;
            sy     <= y0;
            iss    <= 1'b1;
            rd_vld <= 1'b0;
          end
        end
        ST_SUM: begin
          if (rd_vld) begin
            acc <= sum;
            if (rd_last) begin
              total  <= TW'(sum);
              pick_x <= x0;
              pick_y <= y0;
              acc    <= '0;
              cnt    <= '0;
              iss    <= 1'b0;
              rd_vld <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          acc  <= sum;
          frac <= {frac[FRAC_BITS-2:0], 1'b0};
          cnt  <= cnt + FRAC_CNT_BITS'(1);
          if (mul_last) begin
            target   <= sum[PW-1:FRAC_BITS];
            acc      <= '0;
            row_base <= '0;
            sx       <= x0;
            sy       <= y0;
            iss      <= 1'b1;
            rd_vld   <= 1'b0;
          end
        end
        ST_ROWS: begin
          if (rd_vld) begin
            acc <= sum;
            if (rd_eol) begin
              if (hit || rd_last) begin
                // rescan the chosen row from its starting running total
                pick_y <= hit ? rd_y : y1;
                acc    <= hit ? PW'(row_base) : '0;
                sx     <= x0;
                sy     <= hit ? rd_y : y1;
                iss    <= 1'b1;
                rd_vld <= 1'b0;
              end else begin
                row_base <= TW'(sum);
              end
            end
          end
        end
        ST_COLS: begin
          if (rd_vld) begin
            acc <= sum;
            if (hit || rd_last) begin
              pick_x <= hit ? rd_x : x1;
              iss    <= 1'b0;
              rd_vld <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/window_roulette_sampler.sv
// ----------------------------------------------------------------------------
// window_roulette_sampler
// Weighted random cell pick over a rectangular window of a weight grid.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req): a write item stores one
// cell weight and gives no result; a sample item returns one pick on the
// response channel (rsp_valid / rsp_stall / rsp). Window bounds are set over
// the APB-style port; the user must write them only while the block is idle,
// which the block itself does not enforce. A write item keeps req_stall low.
// A sample item occupies the shared adder for a window total pass, 16
// shift-and-add steps for the target, a row pass and a column pass, plus
// the done state that hands the pick to the output register. A zero window
// total skips the multiply and searches. The grid's single read port sets
// the pass lengths: one weight per cycle.
// After reset the grid is swept to zero, one entry per cycle, over all
// 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) entries (256 at the defaults);
// req_stall is high meanwhile, configuration writes are taken.
// A stalled response holds in the output register; the next item is still
// accepted, and its pick waits in the engine until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "window_roulette_sampler_macros.svh"

module window_roulette_sampler #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire wrs_pkg::req_item_t              req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output wrs_pkg::rsp_item_t                   rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wrs_pkg::PADDR_BITS-1:0]  paddr,
  input  wire logic [wrs_pkg::PDATA_BITS-1:0]  pwdata,
  output logic      [wrs_pkg::PDATA_BITS-1:0]  prdata,
  output logic                                 pready
);

  import wrs_pkg::*;

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);

  logic [COORD_BITS-1:0] window_x_low;
  logic [COORD_BITS-1:0] window_x_high;
  logic [COORD_BITS-1:0] window_y_low;
  logic [COORD_BITS-1:0] window_y_high;

  logic [XW-1:0] x0, x1, xh;
  logic [YW-1:0] y0, y1, yh;

  reg_idx_t      reg_idx;
  logic          cfg_wr;
  logic          req_accept;
  logic          res_take;
  eng_status_t   status;
  rsp_item_t     res;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x_low  <= COORD_BITS'(0);
      window_x_high <= COORD_BITS'(15);
      window_y_low  <= COORD_BITS'(0);
      window_y_high <= COORD_BITS'(15);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_X_LOW:  window_x_low  <= pwdata[COORD_BITS-1:0];
        REG_X_HIGH: window_x_high <= pwdata[COORD_BITS-1:0];
        REG_Y_LOW:  window_y_low  <= pwdata[COORD_BITS-1:0];
        REG_Y_HIGH: window_y_high <= pwdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_LOW:  prdata = PDATA_BITS'(window_x_low);
      REG_X_HIGH: prdata = PDATA_BITS'(window_x_high);
      REG_Y_LOW:  prdata = PDATA_BITS'(window_y_low);
      REG_Y_HIGH: prdata = PDATA_BITS'(window_y_high);
      default:    prdata = '0;
    endcase
  end

  // clamp bounds to the grid and raise a high bound that sits below low
  always_comb begin
    x0 = (32'(window_x_low)  >= GRID_WIDTH)  ? XW'(GRID_WIDTH - 1)  : XW'(window_x_low);
    xh = (32'(window_x_high) >= GRID_WIDTH)  ? XW'(GRID_WIDTH - 1)  : XW'(window_x_high);
    y0 = (32'(window_y_low)  >= GRID_HEIGHT) ? YW'(GRID_HEIGHT - 1) : YW'(window_y_low);
    yh = (32'(window_y_high) >= GRID_HEIGHT) ? YW'(GRID_HEIGHT - 1) : YW'(window_y_high);
    x1 = (xh < x0) ? x0 : xh;
    y1 = (yh < y0) ? y0 : yh;
  end

  assign req_stall  = !status.ready;
  assign req_accept = req_valid && !req_stall;
  assign res_take   = !rsp_valid || !rsp_stall;

  wrs_engine #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS),
    .XW          (XW),
    .YW          (YW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .req_accept (req_accept),
    .x0         (x0),
    .x1         (x1),
    .y0         (y0),
    .y1         (y1),
    .res_take   (res_take),
    .status     (status),
    .res        (res)
  );

  // output register: load a finished pick when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.done && res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && res_take) begin
      rsp <= res;
    end
  end

  `WRS_ASSERT_NEXT(a_pick_lands, clk, rst, status.done && !rsp_valid, rsp_valid)
  `WRS_ASSERT_NEXT(a_sample_busy, clk, rst, req_accept && (req.op == OP_SAMPLE), req_stall)
  `WRS_ASSERT_NEXT(a_write_free, clk, rst, req_accept && (req.op == OP_WRITE), !req_stall)
  `WRS_ASSERT_IMPL(a_no_done_idle, clk, rst, status.done, !status.ready)

endmodule

`default_nettype wire
